/* src/pba_pkg.sv */
// Package for the page bitmap allocator: widths, codes, state encoding,
// shared structs and the word-level bit search helpers.
// No dependencies.
`default_nettype none
package pba_pkg;

    localparam int DEF_MAX_PAGES = 4096;
    localparam int WORD_W        = 32;
    localparam int OFS_W         = 5;
    localparam int PG_W          = 14;   // internal page number, holds start + length
    localparam int CMD_W         = 2;
    localparam int START_W       = 12;
    localparam int LEN_W         = 13;
    localparam int MANAGED_W     = 13;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic [MANAGED_W-1:0] MANAGED_RESET = 13'd4096;
    localparam logic [0:0]           REG_MANAGED   = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_RUN_RD,
        ST_RUN_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic            found;
        logic [PG_W-1:0] run_begin;
        logic [PG_W-1:0] count_next;
        logic [PG_W-1:0] head_next;
    } scan_res_t;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] found_page;
    } resp_t;

    // number of consecutive ones from bit 0
    function automatic logic [OFS_W:0] trail_ones(input logic [WORD_W-1:0] v);
        logic [OFS_W:0] n;
        n = (OFS_W+1)'(WORD_W);
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!v[i])
                n = (OFS_W+1)'(i);
        end
        return n;
    endfunction

    // number of consecutive ones from the top bit down
    function automatic logic [OFS_W:0] lead_ones(input logic [WORD_W-1:0] v);
        logic [OFS_W:0] n;
        n = (OFS_W+1)'(WORD_W);
        for (int i = 0; i < WORD_W; i++) begin
            if (!v[i])
                n = (OFS_W+1)'(WORD_W - 1 - i);
        end
        return n;
    endfunction

    function automatic logic [OFS_W-1:0] low_index(input logic [WORD_W-1:0] v);
        logic [OFS_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i])
                idx = OFS_W'(i);
        end
        return idx;
    endfunction

    // bit i set when v[i +: n] is all ones inside the word, n in 1..31
    function automatic logic [WORD_W-1:0] run_starts(input logic [WORD_W-1:0] v,
                                                      input logic [OFS_W-1:0] n);
        logic [WORD_W-1:0] g;
        logic [WORD_W-1:0] r;
        logic [OFS_W-1:0]  off;
        g   = v;
        r   = '1;
        off = '0;
        for (int k = 0; k < OFS_W; k++) begin
            if (n[k]) begin
                r   = r & (g >> off);
                off = off + OFS_W'(1 << k);
            end
            g = g & (g >> (1 << k));
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] span_mask(input logic [OFS_W-1:0] lo,
                                                     input logic [OFS_W-1:0] hi);
        return ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (OFS_W'(WORD_W - 1) - hi));
    endfunction

endpackage
`default_nettype wire

/* src/pba_map_ram.sv */
// Used-page bitmap storage, one 32-page word per entry.
// One write port, one registered read port. Uses pba_pkg.
`default_nettype none
module pba_map_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [pba_pkg::WORD_W-1:0] wr_data,
    input  wire logic [AW-1:0]              rd_addr,
    output logic      [pba_pkg::WORD_W-1:0] rd_data
);

    logic [pba_pkg::WORD_W-1:0] mem [DEPTH];
    logic [pba_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* src/pba_word_unit.sv */
// Scan unit: checks one 32-page word for the first free run,
// carrying the open run across words. Uses pba_pkg.
`default_nettype none
module pba_word_unit (
    input  wire logic [pba_pkg::WORD_W-1:0] data,
    input  wire logic [pba_pkg::PG_W-1:0]   base,
    input  wire logic [pba_pkg::PG_W-1:0]   count,
    input  wire logic [pba_pkg::PG_W-1:0]   run_head,
    input  wire logic [pba_pkg::LEN_W-1:0]  len,
    input  wire logic [pba_pkg::PG_W-1:0]   limit,
    output pba_pkg::scan_res_t              res
);

    logic [pba_pkg::PG_W-1:0]    rem;
    logic [pba_pkg::WORD_W-1:0]  vmask;
    logic [pba_pkg::WORD_W-1:0]  free_bits;
    logic [pba_pkg::OFS_W:0]     tz;
    logic [pba_pkg::OFS_W:0]     lead;
    logic [pba_pkg::PG_W-1:0]    need;
    logic [pba_pkg::WORD_W-1:0]  starts;
    logic [pba_pkg::PG_W-1:0]    head;

    always_comb
    begin
        rem       = limit - base;
        vmask     = (rem >= pba_pkg::PG_W'(pba_pkg::WORD_W)) ? '1 :
                    ((pba_pkg::WORD_W'(1) << rem[pba_pkg::OFS_W-1:0]) - pba_pkg::WORD_W'(1));
        free_bits = ~data & vmask;
        tz        = pba_pkg::trail_ones(free_bits);
        lead      = pba_pkg::lead_ones(free_bits);
        need      = pba_pkg::PG_W'(len) - count;
        starts    = (len < pba_pkg::LEN_W'(pba_pkg::WORD_W)) ?
                    pba_pkg::run_starts(free_bits, len[pba_pkg::OFS_W-1:0]) : '0;
        head      = (count == '0) ? base : run_head;

        res.found     = 1'b0;
        res.run_begin = head;
        if (pba_pkg::PG_W'(tz) >= need)
        begin
            res.found = 1'b1;
        end
        else if (starts != '0)
        begin
            res.found     = 1'b1;
            res.run_begin = base + pba_pkg::PG_W'(pba_pkg::low_index(starts));
        end

        if (tz == (pba_pkg::OFS_W+1)'(pba_pkg::WORD_W))
        begin
            res.count_next = count + pba_pkg::PG_W'(pba_pkg::WORD_W);
            res.head_next  = head;
        end
        else
        begin
            res.count_next = pba_pkg::PG_W'(lead);
            res.head_next  = base + pba_pkg::PG_W'(pba_pkg::WORD_W) - pba_pkg::PG_W'(lead);
        end
    end

endmodule
`default_nettype wire

/* src/pba_seq.sv */
// Command sequencer: clearing pass, word scan for allocate, read-modify-write
// over a run of words. Uses pba_pkg and pba_word_unit.
`default_nettype none
module pba_seq #(
    parameter  int MAX_PAGES = pba_pkg::DEF_MAX_PAGES,
    localparam int NWORDS    = (MAX_PAGES + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W,
    localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [pba_pkg::CMD_W-1:0]     in_cmd,
    input  wire logic [pba_pkg::START_W-1:0]   in_start,
    input  wire logic [pba_pkg::LEN_W-1:0]     in_len,
    input  wire logic [pba_pkg::MANAGED_W-1:0] managed,
    output logic                               resp_valid,
    input  wire logic                          resp_ready,
    output pba_pkg::resp_t                     resp,
    output logic      [AW-1:0]                 rd_addr,
    input  wire logic [pba_pkg::WORD_W-1:0]    rd_data,
    output logic                               wr_en,
    output logic      [AW-1:0]                 wr_addr,
    output logic      [pba_pkg::WORD_W-1:0]    wr_data
);

    localparam int PageCapI = (MAX_PAGES < 16383) ? MAX_PAGES : 16383;
    localparam logic [pba_pkg::PG_W-1:0] PAGE_CAP  = pba_pkg::PG_W'(PageCapI);
    localparam logic [AW-1:0]            LAST_WORD = AW'(NWORDS - 1);

    pba_pkg::state_t state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [pba_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [pba_pkg::PG_W-1:0]    cur_reg, cur_next;
    logic [pba_pkg::PG_W-1:0]    last_reg, last_next;
    logic [pba_pkg::PG_W-1:0]    count_reg, count_next;
    logic [pba_pkg::PG_W-1:0]    head_reg, head_next;
    logic [pba_pkg::PG_W-1:0]    limit_reg, limit_next;
    logic                        set_reg, set_next;
    logic                        ok_reg, ok_next;
    logic [pba_pkg::START_W-1:0] found_reg, found_next;

    pba_pkg::scan_res_t          scan;
    logic [pba_pkg::PG_W-1:0]    in_last;
    logic                        in_empty;
    logic                        same_word;
    logic [pba_pkg::WORD_W-1:0]  mask;
    logic [pba_pkg::PG_W-1:0]    managed_ext;

    pba_word_unit u_word (
        .data     (rd_data),
        .base     (cur_reg),
        .count    (count_reg),
        .run_head (head_reg),
        .len      (len_reg),
        .limit    (limit_reg),
        .res      (scan)
    );

    assign in_last     = pba_pkg::PG_W'(in_start) + pba_pkg::PG_W'(in_len) - pba_pkg::PG_W'(1);
    assign in_empty    = (in_len == '0) || (pba_pkg::PG_W'(in_start) >= PAGE_CAP);
    assign same_word   = (cur_reg[pba_pkg::PG_W-1:pba_pkg::OFS_W] ==
                          last_reg[pba_pkg::PG_W-1:pba_pkg::OFS_W]);
    assign managed_ext = pba_pkg::PG_W'(managed);
    assign mask        = pba_pkg::span_mask(cur_reg[pba_pkg::OFS_W-1:0],
                             same_word ? last_reg[pba_pkg::OFS_W-1:0] : '1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pba_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_WORD)
                    state_next = pba_pkg::ST_IDLE;
            end
            pba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_cmd)
                        pba_pkg::CMD_ALLOC:
                            state_next = (in_len == '0) ? pba_pkg::ST_RESP : pba_pkg::ST_SCAN;
                        pba_pkg::CMD_FREE,
                        pba_pkg::CMD_RESERVE:
                            state_next = in_empty ? pba_pkg::ST_RESP : pba_pkg::ST_RUN_RD;
                        default:
                            state_next = pba_pkg::ST_RESP;
                    endcase
                end
            end
            pba_pkg::ST_SCAN:
            begin
                if (cur_reg >= limit_reg)
                    state_next = pba_pkg::ST_RESP;
                else if (scan.found)
                    state_next = pba_pkg::ST_RUN_RD;
            end
            pba_pkg::ST_RUN_RD:
                state_next = pba_pkg::ST_RUN_WR;
            pba_pkg::ST_RUN_WR:
                state_next = same_word ? pba_pkg::ST_RESP : pba_pkg::ST_RUN_RD;
            pba_pkg::ST_RESP:
            begin
                if (resp_ready)
                    state_next = pba_pkg::ST_IDLE;
            end
            default:
                state_next = pba_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next   = clr_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        last_next  = last_reg;
        count_next = count_reg;
        head_next  = head_reg;
        limit_next = limit_reg;
        set_next   = set_reg;
        ok_next    = ok_reg;
        found_next = found_reg;
        in_ready   = 1'b0;
        resp_valid = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = AW'(cur_reg >> pba_pkg::OFS_W);
        wr_data    = set_reg ? (rd_data | mask) : (rd_data & ~mask);

        case (state_reg)
            pba_pkg::ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '1;
                clr_next = clr_reg + AW'(1);
            end
            pba_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                len_next   = in_len;
                count_next = '0;
                head_next  = '0;
                limit_next = (managed_ext < PAGE_CAP) ? managed_ext : PAGE_CAP;
                found_next = '0;
                last_next  = (in_last >= PAGE_CAP) ? (PAGE_CAP - pba_pkg::PG_W'(1)) : in_last;
                set_next   = (in_cmd == pba_pkg::CMD_RESERVE);
                ok_next    = (in_cmd == pba_pkg::CMD_FREE) || (in_cmd == pba_pkg::CMD_RESERVE);
                cur_next   = (in_cmd == pba_pkg::CMD_ALLOC) ? '0 : pba_pkg::PG_W'(in_start);
            end
            pba_pkg::ST_SCAN:
            begin
                if (cur_reg < limit_reg)
                begin
                    if (scan.found)
                    begin
                        cur_next   = scan.run_begin;
                        last_next  = scan.run_begin + pba_pkg::PG_W'(len_reg) - pba_pkg::PG_W'(1);
                        set_next   = 1'b1;
                        ok_next    = 1'b1;
                        found_next = scan.run_begin[pba_pkg::START_W-1:0];
                    end
                    else
                    begin
                        cur_next   = cur_reg + pba_pkg::PG_W'(pba_pkg::WORD_W);
                        count_next = scan.count_next;
                        head_next  = scan.head_next;
                    end
                end
            end
            pba_pkg::ST_RUN_RD:
            begin
            end
            pba_pkg::ST_RUN_WR:
            begin
                wr_en    = 1'b1;
                cur_next = {cur_reg[pba_pkg::PG_W-1:pba_pkg::OFS_W] +
                            (pba_pkg::PG_W-pba_pkg::OFS_W)'(1),
                            {pba_pkg::OFS_W{1'b0}}};
            end
            pba_pkg::ST_RESP:
                resp_valid = 1'b1;
            default:
            begin
            end
        endcase

        rd_addr = AW'(cur_next >> pba_pkg::OFS_W);
    end

    assign resp.success    = ok_reg;
    assign resp.found_page = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pba_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        cur_reg   <= cur_next;
        last_reg  <= last_next;
        count_reg <= count_next;
        head_reg  <= head_next;
        limit_reg <= limit_next;
        set_reg   <= set_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
    end

    a_zero_alloc_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_cmd == pba_pkg::CMD_ALLOC && in_len == '0)
        |=> (state_reg == pba_pkg::ST_RESP && !ok_reg))
        else $error("zero-length allocate did not fail at once");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == pba_pkg::ST_CLEAR || state_reg == pba_pkg::ST_RUN_WR))
        else $error("bitmap written outside clear or run update");

    a_open_run_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pba_pkg::ST_SCAN) |-> (count_reg < pba_pkg::PG_W'(len_reg)))
        else $error("open free run reached the length without a hit");

    a_fail_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && !resp.success) |-> (resp.found_page == '0))
        else $error("failed result carries a page");

endmodule
`default_nettype wire

/* src/page_bitmap_allocator.sv */
// Top level of the first-fit page bitmap allocator: APB register, output
// beat register, bitmap RAM and sequencer. Uses pba_pkg, pba_map_ram, pba_seq.
//
//  channel  dir  handshake            beat contents
//  s_*      in   s_tvalid / s_tready  command, first_page, run_length
//  m_*      out  m_tvalid / m_tready  success, found_page
//  apb      in   psel/penable/pready  managed_pages at address 0
//
// After reset a clearing pass sets every used bit, word by word; no beat is
// taken meanwhile. Allocate: the words are scanned in order up to the hit
// or the managed limit, then each word of the run is read and written back.
// Free/reserve: each word touched is read and written back.
// A finished result sits in the output register; s_tready returns once the
// result has moved into that register, which happens when it has room.
`default_nettype none
module page_bitmap_allocator #(
    parameter int MAX_PAGES = pba_pkg::DEF_MAX_PAGES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [31:0]                  s_tdata,   // command[1:0], first_page[13:2], run_length[26:14]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [15:0]                  m_tdata,   // success[0], found_page[12:1]
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pba_pkg::APB_AW-1:0]   paddr,
    input  wire logic [pba_pkg::APB_DW-1:0]   pwdata,
    output logic      [pba_pkg::APB_DW-1:0]   prdata,
    output logic                              pready
);

    localparam int NWORDS = (MAX_PAGES + pba_pkg::WORD_W - 1) / pba_pkg::WORD_W;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    logic [pba_pkg::MANAGED_W-1:0] managed_reg, managed_next;
    logic                          out_valid_reg, out_valid_next;
    pba_pkg::resp_t                out_data_reg, out_data_next;

    logic                          resp_valid;
    logic                          resp_ready;
    pba_pkg::resp_t                resp;
    logic [AW-1:0]                 rd_addr;
    logic [pba_pkg::WORD_W-1:0]    rd_data;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [pba_pkg::WORD_W-1:0]    wr_data;
    logic                          reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == pba_pkg::REG_MANAGED);
    assign prdata  = reg_hit ? pba_pkg::APB_DW'(managed_reg) : '0;

    always_comb
    begin
        managed_next = managed_reg;
        if (psel && penable && pwrite && pready && reg_hit)
            managed_next = pwdata[pba_pkg::MANAGED_W-1:0];
    end

    assign resp_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
            out_valid_next = 1'b0;
        if (resp_valid && resp_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = resp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            managed_reg   <= pba_pkg::MANAGED_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            managed_reg   <= managed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.found_page, out_data_reg.success};

    pba_map_ram #(
        .DEPTH (NWORDS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pba_seq #(
        .MAX_PAGES (MAX_PAGES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tdata[1:0]),
        .in_start   (s_tdata[13:2]),
        .in_len     (s_tdata[26:14]),
        .managed    (managed_reg),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

endmodule
`default_nettype wire
